### rtl/fth_pkg.sv
// shared types, constants and helper functions for the flow tuple hash table
`timescale 1ns / 1ps

package fth_pkg;

	localparam int BUCKET_BITS_DEF = 10;
	localparam int WAYS_DEF        = 4;

	localparam int TUPLE_W   = 96;
	localparam int COUNT_W   = 16;
	localparam int ENTRY_W   = 1 + TUPLE_W + COUNT_W;
	localparam int BIDX_W    = 10;
	localparam int STATUS_W  = 3;
	localparam int S_DATA_W  = 104;
	localparam int M_DATA_W  = 32;

	localparam logic [31:0] MIX_INIT   = 32'hdeadbeef;
	localparam logic [31:0] SEED_RESET = 32'h05123598;
	localparam int          MIX_STEPS  = 7;

	typedef enum logic [1:0] {
		OP_CREATE,
		OP_UPDATE,
		OP_DELETE,
		OP_UNUSED
	} op_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_DUP,
		ST_FULL,
		ST_MISS,
		ST_ODD
	} status_t;

	typedef enum logic [1:0] {
		TGT_X,
		TGT_Y,
		TGT_Z
	} mix_tgt_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_MIX,
		S_READ,
		S_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic init;
		logic mix;
		logic rd;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mix_last;
	} dp_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] w, input logic [4:0] s);
		logic [63:0] tmp;
		tmp = {w, w} << s;
		return tmp[63:32];
	endfunction

	// rotation amount of each final-mix step
	function automatic logic [4:0] mix_rot(input logic [2:0] step);
		logic [4:0] r;
		unique case (step)
			3'd0:    r = 5'd14;
			3'd1:    r = 5'd11;
			3'd2:    r = 5'd25;
			3'd3:    r = 5'd16;
			3'd4:    r = 5'd4;
			3'd5:    r = 5'd14;
			default: r = 5'd24;
		endcase
		return r;
	endfunction

	// word rewritten by each final-mix step
	function automatic mix_tgt_t mix_tgt(input logic [2:0] step);
		mix_tgt_t t;
		unique case (step)
			3'd0, 3'd3, 3'd6: t = TGT_Z;
			3'd1, 3'd4, 3'd7: t = TGT_X;
			default:          t = TGT_Y;
		endcase
		return t;
	endfunction

endpackage

### rtl/fth_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module fth_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/fth_dp.sv
// datapath: tuple capture, jhash final mix, bucket row update and result register
`timescale 1ns / 1ps

module fth_dp #(
	parameter int BUCKET_BITS = fth_pkg::BUCKET_BITS_DEF,
	parameter int WAYS        = fth_pkg::WAYS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fth_pkg::dp_cmd_t                      cmd,
	output fth_pkg::dp_stat_t                     stat,
	input  logic [31:0]                           hash_seed,
	input  logic [fth_pkg::S_DATA_W-1:0]          s_tdata,
	output logic [fth_pkg::M_DATA_W-1:0]          m_tdata
);

	localparam int ROW_W = WAYS * fth_pkg::ENTRY_W;
	localparam int CW    = fth_pkg::COUNT_W;
	localparam int TW    = fth_pkg::TUPLE_W;

	fth_pkg::op_t                op_q;
	logic [31:0]                 sa_q, da_q;
	logic [15:0]                 sp_q, dp_q;
	logic [31:0]                 x_q, y_q, z_q;
	logic [2:0]                  step_q;
	logic [BUCKET_BITS-1:0]      clr_q;
	logic [fth_pkg::STATUS_W-1:0] res_status_q;
	logic [CW-1:0]               res_count_q;
	logic [fth_pkg::BIDX_W-1:0]  res_bidx_q;

	logic [31:0]                 f, src_w, mixed;
	logic [4:0]                  rot;
	fth_pkg::mix_tgt_t           tgt;
	logic [TW-1:0]               tuple;
	logic [ROW_W-1:0]            rd_row, wr_row, new_row;
	logic [WAYS-1:0]             vld, match, hit_oh, nv, free_oh;
	logic                        any_hit, any_free, row_we, ram_we;
	logic [CW-1:0]               hit_cnt, inc_cnt;
	logic [fth_pkg::STATUS_W-1:0] status_n;
	logic [CW-1:0]               count_n;
	logic [BUCKET_BITS-1:0]      waddr;

	assign tuple = {sa_q, da_q, sp_q, dp_q};
	assign f     = (sa_q + {16'd0, sp_q}) ^ (da_q + {16'd0, dp_q});
	assign rot   = fth_pkg::mix_rot(step_q);
	assign tgt   = fth_pkg::mix_tgt(step_q);

	always_comb begin
		unique case (tgt)
			fth_pkg::TGT_Z: src_w = y_q;
			fth_pkg::TGT_X: src_w = z_q;
			default:        src_w = x_q;
		endcase
		unique case (tgt)
			fth_pkg::TGT_Z: mixed = (z_q ^ src_w) - fth_pkg::rotl(src_w, rot);
			fth_pkg::TGT_X: mixed = (x_q ^ src_w) - fth_pkg::rotl(src_w, rot);
			default:        mixed = (y_q ^ src_w) - fth_pkg::rotl(src_w, rot);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= fth_pkg::op_t'(s_tdata[1:0]);
			sa_q <= s_tdata[33:2];
			da_q <= s_tdata[65:34];
			sp_q <= s_tdata[81:66];
			dp_q <= s_tdata[97:82];
		end
		if (cmd.init) begin
			x_q <= f + fth_pkg::MIX_INIT;
			y_q <= f + fth_pkg::MIX_INIT;
			z_q <= (f | (f << 16)) + hash_seed;
		end else if (cmd.mix) begin
			unique case (tgt)
				fth_pkg::TGT_Z: z_q <= mixed;
				fth_pkg::TGT_X: x_q <= mixed;
				default:        y_q <= mixed;
			endcase
		end
		if (cmd.exec) begin
			res_status_q <= status_n;
			res_count_q  <= count_n;
			res_bidx_q   <= fth_pkg::BIDX_W'(z_q[BUCKET_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.init) begin
				step_q <= '0;
			end else if (cmd.mix) begin
				step_q <= step_q + 3'd1;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + BUCKET_BITS'(1);
			end
		end
	end

	assign stat.mix_last = (step_q == 3'(fth_pkg::MIX_STEPS - 1));
	assign stat.clr_last = (clr_q == {BUCKET_BITS{1'b1}});

	// way compare and row rewrite
	always_comb begin
		hit_cnt = '0;
		for (int w = 0; w < WAYS; w++) begin
			vld[w]   = rd_row[w*fth_pkg::ENTRY_W];
			match[w] = vld[w] && (rd_row[w*fth_pkg::ENTRY_W+1 +: TW] == tuple);
		end
		nv       = ~vld;
		hit_oh   = match & (~match + WAYS'(1));
		free_oh  = nv & (~nv + WAYS'(1));
		any_hit  = |match;
		any_free = |nv;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_oh[w]) begin
				hit_cnt = rd_row[w*fth_pkg::ENTRY_W+1+TW +: CW];
			end
		end
		inc_cnt = hit_cnt + CW'(1);
		new_row = rd_row;
		for (int w = 0; w < WAYS; w++) begin
			if (op_q == fth_pkg::OP_CREATE && !any_hit && free_oh[w]) begin
				new_row[w*fth_pkg::ENTRY_W +: fth_pkg::ENTRY_W] = {CW'(1), tuple, 1'b1};
			end
			if (op_q == fth_pkg::OP_UPDATE && hit_oh[w]) begin
				new_row[w*fth_pkg::ENTRY_W+1+TW +: CW] = inc_cnt;
			end
			if (op_q == fth_pkg::OP_DELETE && hit_oh[w]) begin
				new_row[w*fth_pkg::ENTRY_W] = 1'b0;
			end
		end
		row_we   = 1'b0;
		status_n = fth_pkg::ST_MISS;
		count_n  = '0;
		unique case (op_q)
			fth_pkg::OP_CREATE: begin
				if (any_hit) begin
					status_n = fth_pkg::ST_DUP;
					count_n  = hit_cnt;
				end else if (any_free) begin
					row_we   = 1'b1;
					status_n = fth_pkg::ST_OK;
					count_n  = CW'(1);
				end else begin
					status_n = fth_pkg::ST_FULL;
				end
			end
			fth_pkg::OP_UPDATE: begin
				if (any_hit) begin
					row_we   = 1'b1;
					count_n  = inc_cnt;
					status_n = inc_cnt[0] ? fth_pkg::ST_ODD : fth_pkg::ST_OK;
				end
			end
			fth_pkg::OP_DELETE: begin
				if (any_hit) begin
					row_we   = 1'b1;
					status_n = fth_pkg::ST_OK;
				end
			end
			default: begin
				row_we = 1'b0;
			end
		endcase
	end

	assign ram_we = cmd.clr || (cmd.exec && row_we);
	assign waddr  = cmd.clr ? clr_q : z_q[BUCKET_BITS-1:0];
	assign wr_row = cmd.clr ? '0 : new_row;

	fth_ram #(
		.WIDTH(ROW_W),
		.DEPTH(1 << BUCKET_BITS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wr_row),
		.re   (cmd.rd),
		.raddr(z_q[BUCKET_BITS-1:0]),
		.rdata(rd_row)
	);

	assign m_tdata = {3'd0, res_bidx_q, res_count_q, res_status_q};

endmodule

### rtl/fth_ctrl.sv
// controller: clearing pass, hash sequencing, table access and output handshake
`timescale 1ns / 1ps

module fth_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output fth_pkg::dp_cmd_t  cmd,
	input  fth_pkg::dp_stat_t stat
);

	fth_pkg::ctrl_state_t state_q, state_n;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fth_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			fth_pkg::S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_n = fth_pkg::S_IDLE;
				end
			end
			fth_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_n  = fth_pkg::S_INIT;
				end
			end
			fth_pkg::S_INIT: begin
				cmd.init = 1'b1;
				state_n  = fth_pkg::S_MIX;
			end
			fth_pkg::S_MIX: begin
				cmd.mix = 1'b1;
				if (stat.mix_last) begin
					state_n = fth_pkg::S_READ;
				end
			end
			fth_pkg::S_READ: begin
				cmd.rd  = 1'b1;
				state_n = fth_pkg::S_EXEC;
			end
			fth_pkg::S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_n  = fth_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = fth_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/flow_tuple_hash_table.sv
// top level of the flow tuple hash table
`timescale 1ns / 1ps

// set-associative connection table keyed by a tcp/ip four-tuple. each input
// transaction carries an opcode (create, update, delete) and the tuple; the
// tuple is folded and run through the jhash final mix with hash_seed, and the
// low BUCKET_BITS pick a bucket row of WAYS entries held in one ram row.
// every input transaction gives exactly one output transaction with status,
// fragment count and bucket index. an item passes through acceptance and
// load, mix init, seven mix steps (one shared rotate-xor-subtract unit, one
// step a cycle), ram read and a read-modify-write of the row. the result is
// registered and presented as the row is written back, and the next item is
// taken in the cycle after the write-back, so items never overlap; a
// result still waiting on the output holds the write-back until it is taken.
// after reset a clearing pass writes every bucket row to zero, during which
// no transaction is accepted. hash_seed should only be written while idle.
module flow_tuple_hash_table_core #(
	parameter int BUCKET_BITS = fth_pkg::BUCKET_BITS_DEF,
	parameter int WAYS        = fth_pkg::WAYS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [31:0]                  cfg_wdata,   // hash_seed
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// opcode, src_addr, dst_addr, src_port, dst_port
	input  logic [fth_pkg::S_DATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status, frag_count, bucket_index
	output logic [fth_pkg::M_DATA_W-1:0] m_tdata
);

	logic [31:0]       seed_q;
	fth_pkg::dp_cmd_t  cmd;
	fth_pkg::dp_stat_t stat;

	// seed register, reset to the standard value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= fth_pkg::SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	fth_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	fth_dp #(
		.BUCKET_BITS(BUCKET_BITS),
		.WAYS       (WAYS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.hash_seed(seed_q),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata)
	);

endmodule
